// ===== rtl/sem_pkg.sv =====
// Package for the Sobel edge magnitude block: widths, reset values,
// register and state codes, and the configuration struct. No dependencies.
package sem_pkg;

    localparam int unsigned DEF_MAX_WIDTH = 4096;

    localparam int PIX_W   = 8;
    localparam int POS_W   = 12;
    localparam int SIZE_W  = 13;
    localparam int GRAD_W  = 11;
    localparam int SUM_W   = 22;
    localparam int ROOT_W  = 16;
    localparam int MAG_W   = 8;
    localparam int APB_W   = 32;
    localparam int PADDR_W = 3;

    localparam logic [SIZE_W-1:0] WIDTH_RESET  = 13'd640;
    localparam logic [SIZE_W-1:0] HEIGHT_RESET = 13'd480;
    localparam logic [SIZE_W-1:0] SIZE_MIN     = 13'd3;
    localparam logic [SIZE_W-1:0] SIZE_MAX     = 13'd4096;
    localparam logic [MAG_W-1:0]  MAG_SAT      = 8'd255;

    typedef enum logic
    {
        REG_WIDTH  = 1'b0,
        REG_HEIGHT = 1'b1
    } sem_reg_t;

    typedef enum logic [2:0]
    {
        S_IDLE,
        S_READ,
        S_SQUARE,
        S_ROOT,
        S_OUT
    } sem_state_t;

    typedef struct packed
    {
        logic [SIZE_W-1:0] width;
        logic [SIZE_W-1:0] height;
        logic              restart;
    } sem_cfg_t;

endpackage

// ===== rtl/sobel_edge_magnitude.sv =====
// Top level of the streaming 3x3 Sobel edge magnitude block: sequencer,
// window, counters and output register. Depends on sem_pkg, sem_ram,
// sem_cfg and sem_isqrt.
//
//   channel  direction  handshake                         word
//   pixel    in         in_valid / in_stall               pixel_value
//   result   out        out_valid / out_stall             magnitude, row, col, done
//   config   in         APB psel/penable/pwrite, pready   13-bit width, height
//
// A pixel without a result goes through a line store read and a write back.
// An interior pixel goes through read, gradient, square, 8 root steps,
// root done and output load; the bit-serial root is the longest of these.
// The output register holds a result while the next pixel is taken; the
// block waits in its last step only when that register is still full.
// Reset clears counters and window; line stores need no clearing.
module sobel_edge_magnitude
    import sem_pkg::*;
#(
    parameter int unsigned MAX_WIDTH = DEF_MAX_WIDTH
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [APB_W-1:0]   pwdata,
    output logic [APB_W-1:0]   prdata,
    output logic               pready,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [PIX_W-1:0]   pixel_value,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [MAG_W-1:0]   edge_magnitude,
    output logic [POS_W-1:0]   centre_row,
    output logic [POS_W-1:0]   centre_col,
    output logic               frame_done
);

    localparam int ADDR_W = $clog2(MAX_WIDTH);

    sem_cfg_t   cfg;
    sem_state_t state_reg, state_next;

    logic [POS_W-1:0]   col_reg, row_reg;
    logic [POS_W-1:0]   cur_col_reg, cur_row_reg;
    logic [PIX_W-1:0]   pix_reg;
    logic [PIX_W-1:0]   win_reg [6];
    logic               emit_reg, last_reg, sat_reg;
    logic signed [GRAD_W-1:0] gx_reg, gy_reg;

    logic               out_valid_reg;
    logic [MAG_W-1:0]   mag_reg;
    logic [POS_W-1:0]   orow_reg, ocol_reg;
    logic               odone_reg;

    logic               accept, ram_we, root_start, out_load;
    logic [2*PIX_W-1:0] ram_rdata;
    logic [PIX_W-1:0]   top, mid;
    logic [SIZE_W-1:0]  col_plus, row_plus;
    logic signed [GRAD_W-1:0] gx, gy;
    logic signed [2*GRAD_W-1:0] sqx, sqy;
    logic [SUM_W-1:0]   sum;
    logic               root_done;
    logic [MAG_W-1:0]   root;

    sem_cfg #(.MAX_WIDTH(MAX_WIDTH)) u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // upper row in the high byte, middle row in the low byte
    sem_ram #(.WIDTH(2*PIX_W), .DEPTH(MAX_WIDTH)) u_lines (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ADDR_W'(cur_col_reg)),
        .wdata ({mid, pix_reg}),
        .raddr (ADDR_W'(col_reg)),
        .rdata (ram_rdata)
    );

    sem_isqrt u_root (
        .clk   (clk),
        .rst_n (rst_n),
        .start (root_start),
        .value (sum[ROOT_W-1:0]),
        .done  (root_done),
        .root  (root)
    );

    assign top = ram_rdata[2*PIX_W-1:PIX_W];
    assign mid = ram_rdata[PIX_W-1:0];

    assign gx = (GRAD_W'($signed({1'b0, top})) - GRAD_W'($signed({1'b0, win_reg[0]})))
              + ((GRAD_W'($signed({1'b0, mid})) - GRAD_W'($signed({1'b0, win_reg[1]}))) <<< 1)
              + (GRAD_W'($signed({1'b0, pix_reg})) - GRAD_W'($signed({1'b0, win_reg[2]})));
    assign gy = (GRAD_W'($signed({1'b0, win_reg[2]})) + GRAD_W'($signed({1'b0, pix_reg}))
              + (GRAD_W'($signed({1'b0, win_reg[5]})) <<< 1))
              - (GRAD_W'($signed({1'b0, win_reg[0]})) + GRAD_W'($signed({1'b0, top}))
              + (GRAD_W'($signed({1'b0, win_reg[3]})) <<< 1));

    assign sqx = gx_reg * gx_reg;
    assign sqy = gy_reg * gy_reg;
    assign sum = SUM_W'(sqx) + SUM_W'(sqy);

    assign col_plus = {1'b0, col_reg} + SIZE_W'(1);
    assign row_plus = {1'b0, row_reg} + SIZE_W'(1);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                    state_next = S_READ;
            end
            S_READ:
            begin
                state_next = emit_reg ? S_SQUARE : S_IDLE;
            end
            S_SQUARE:
            begin
                state_next = S_ROOT;
            end
            S_ROOT:
            begin
                if (root_done)
                    state_next = S_OUT;
            end
            S_OUT:
            begin
                if (!out_valid_reg || !out_stall)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_stall   = 1'b1;
        ram_we     = 1'b0;
        root_start = 1'b0;
        out_load   = 1'b0;
        unique case (state_reg)
            S_IDLE:   in_stall   = 1'b0;
            S_READ:   ram_we     = 1'b1;
            S_SQUARE: root_start = 1'b1;
            S_ROOT:   out_load   = 1'b0;
            S_OUT:    out_load   = !out_valid_reg || !out_stall;
            default:  in_stall   = 1'b1;
        endcase
    end

    assign accept = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            col_reg       <= '0;
            row_reg       <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < 6; i++)
            begin
                win_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            if (cfg.restart)
            begin
                col_reg <= '0;
                row_reg <= '0;
            end
            else if (accept)
            begin
                if (col_plus >= cfg.width)
                begin
                    col_reg <= '0;
                    row_reg <= (row_plus >= cfg.height) ? '0 : row_plus[POS_W-1:0];
                end
                else
                begin
                    col_reg <= col_plus[POS_W-1:0];
                end
            end
            if (ram_we)
            begin
                win_reg[0] <= win_reg[3];
                win_reg[1] <= win_reg[4];
                win_reg[2] <= win_reg[5];
                win_reg[3] <= top;
                win_reg[4] <= mid;
                win_reg[5] <= pix_reg;
            end
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            pix_reg     <= pixel_value;
            cur_col_reg <= col_reg;
            cur_row_reg <= row_reg;
            emit_reg    <= (row_reg >= POS_W'(2)) && (col_reg >= POS_W'(2));
            last_reg    <= (row_plus == cfg.height) && (col_plus == cfg.width);
        end
        if (ram_we)
        begin
            gx_reg <= gx;
            gy_reg <= gy;
        end
        if (root_start)
            sat_reg <= |sum[SUM_W-1:ROOT_W];
        if (out_load)
        begin
            mag_reg   <= sat_reg ? MAG_SAT : root;
            orow_reg  <= cur_row_reg - POS_W'(1);
            ocol_reg  <= cur_col_reg - POS_W'(1);
            odone_reg <= last_reg;
        end
    end

    assign out_valid      = out_valid_reg;
    assign edge_magnitude = mag_reg;
    assign centre_row     = orow_reg;
    assign centre_col     = ocol_reg;
    assign frame_done     = odone_reg;

endmodule

// ===== rtl/sem_ram.sv =====
// Generic single-clock RAM, one write port and one registered read port.
// No dependencies.
module sem_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/sem_cfg.sv =====
// APB register file: image width and height, clamped to the legal sizes.
// Depends on sem_pkg.
module sem_cfg
    import sem_pkg::*;
#(
    parameter int unsigned MAX_WIDTH = DEF_MAX_WIDTH
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [APB_W-1:0]   pwdata,
    output logic [APB_W-1:0]   prdata,
    output logic               pready,
    output sem_cfg_t           cfg
);

    localparam logic [SIZE_W-1:0] WIDTH_CAP =
        (MAX_WIDTH < 4096) ? SIZE_W'(MAX_WIDTH) : SIZE_MAX;

    logic [SIZE_W-1:0] width_reg, width_next;
    logic [SIZE_W-1:0] height_reg, height_next;
    logic              wr;
    sem_reg_t          sel;

    assign wr     = psel && penable && pwrite;
    assign sel    = sem_reg_t'(paddr[2]);
    assign pready = 1'b1;

    always_comb
    begin
        width_next  = width_reg;
        height_next = height_reg;
        prdata      = '0;
        unique case (sel)
            REG_WIDTH:
            begin
                prdata = APB_W'(width_reg);
                if (wr)
                begin
                    width_next = pwdata[SIZE_W-1:0];
                end
            end
            REG_HEIGHT:
            begin
                prdata = APB_W'(height_reg);
                if (wr)
                begin
                    height_next = pwdata[SIZE_W-1:0];
                end
            end
            default:
            begin
                prdata = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= WIDTH_RESET;
            height_reg <= HEIGHT_RESET;
        end
        else
        begin
            width_reg  <= width_next;
            height_reg <= height_next;
        end
    end

    always_comb
    begin
        if (width_reg < SIZE_MIN)
            cfg.width = SIZE_MIN;
        else if (width_reg > WIDTH_CAP)
            cfg.width = WIDTH_CAP;
        else
            cfg.width = width_reg;

        if (height_reg < SIZE_MIN)
            cfg.height = SIZE_MIN;
        else if (height_reg > SIZE_MAX)
            cfg.height = SIZE_MAX;
        else
            cfg.height = height_reg;

        cfg.restart = wr;
    end

endmodule

// ===== rtl/sem_isqrt.sv =====
// Digit-by-digit integer square root of a 16-bit value, one result bit
// per cycle. Depends on sem_pkg.
module sem_isqrt
    import sem_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [ROOT_W-1:0] value,
    output logic              done,
    output logic [MAG_W-1:0]  root
);

    logic [ROOT_W-1:0] val_reg, val_next;
    logic [9:0]        rem_reg, rem_next;
    logic [MAG_W-1:0]  res_reg, res_next;
    logic [2:0]        cnt_reg, cnt_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [9:0]        rem_sh;
    logic [9:0]        trial;

    assign rem_sh = {rem_reg[7:0], val_reg[ROOT_W-1 -: 2]};
    assign trial  = {res_reg, 2'b01};

    always_comb
    begin
        val_next  = val_reg;
        rem_next  = rem_reg;
        res_next  = res_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            val_next  = value;
            rem_next  = '0;
            res_next  = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            val_next = {val_reg[ROOT_W-3:0], 2'b00};
            if (rem_sh >= trial)
            begin
                rem_next = rem_sh - trial;
                res_next = {res_reg[MAG_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = rem_sh;
                res_next = {res_reg[MAG_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 3'd1;
            if (cnt_reg == 3'd7)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg <= val_next;
        rem_reg <= rem_next;
        res_reg <= res_next;
    end

    assign done = done_reg;
    assign root = res_reg;

endmodule

// ===== rtl/sem_checker.sv =====
// Port-level checks for sobel_edge_magnitude, bound to the top level.
// Depends on sem_pkg.
module sem_checker
    import sem_pkg::*;
(
    input logic             clk,
    input logic             rst_n,
    input logic             in_valid,
    input logic             in_stall,
    input logic             out_valid,
    input logic             out_stall,
    input logic [MAG_W-1:0] edge_magnitude,
    input logic [POS_W-1:0] centre_row,
    input logic [POS_W-1:0] centre_col,
    input logic             frame_done
);

    a_reset_empty: assert property (@(posedge clk) !rst_n |-> !out_valid)
        else $error("result valid during reset");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(edge_magnitude)
            && $stable(centre_row) && $stable(centre_col) && $stable(frame_done))
        else $error("stalled result word changed");

    a_interior: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> centre_row != '0 && centre_col != '0)
        else $error("border pixel emitted");

    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("second pixel taken while the first is in the line stores");

    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> !$rose(out_valid))
        else $error("result appeared one cycle after its pixel");

endmodule

bind sobel_edge_magnitude sem_checker u_sem_checker (.*);
